// ----- design/lttb_downsample_selector_macros.svh -----
// ----------------------------------------------------------------------------
// LTTB selector assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LTTB_DOWNSAMPLE_SELECTOR_MACROS_SVH
`define LTTB_DOWNSAMPLE_SELECTOR_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define LTTBDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define LTTBDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lttbds_pkg.sv -----
// ----------------------------------------------------------------------------
// lttbds_pkg
// Shared types and constants of the LTTB downsampling selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lttbds_pkg;

    localparam int CFG_W          = 13;   // configuration data width
    localparam int KEPT_W         = 12;   // kept index width
    localparam int MIN_OUT_POINTS = 3;

    typedef enum logic [0:0] {
        REG_NUM_SAMPLES = 1'b0,
        REG_OUT_POINTS  = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_PREP,
        S_DIV,
        S_INIT,
        S_IDLE,
        S_SETUP_A,
        S_SETUP_B,
        S_SETUP_C,
        S_WALK_RD,
        S_WALK_MUL,
        S_WALK_CMP,
        S_EMIT_SEL,
        S_EMIT_LAST
    } t_state;

endpackage

`default_nettype wire

// ----- design/lttbds_sample_if.sv -----
// ----------------------------------------------------------------------------
// lttbds_sample_if
// Sample channel: valid/ready handshake carrying one signed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface lttbds_sample_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- design/lttbds_result_if.sv -----
// ----------------------------------------------------------------------------
// lttbds_result_if
// Result channel: valid/ready handshake carrying a kept index and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lttbds_result_if;
    import lttbds_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEPT_W-1:0] kept_index;
    logic              last;

    modport source (output valid, output kept_index, output last, input ready);
    modport sink   (input valid, input kept_index, input last, output ready);
endinterface

`default_nettype wire

// ----- design/lttbds_div.sv -----
// ----------------------------------------------------------------------------
// lttbds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lttbds_div #(
    parameter int W = 13
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W:0]       w_trial;
    logic             w_fits;

    assign w_trial = {r_rem[W-1:0], r_quo[W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? (w_trial - {1'b0, r_dvs}) : w_trial;
            r_quo <= {r_quo[W-2:0], w_fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[W-1:0];
endmodule

`default_nettype wire

// ----- design/lttb_downsample_selector.sv -----
// ----------------------------------------------------------------------------
// lttb_downsample_selector
// Largest-Triangle-Three-Buckets index selector over a stored sample series.
// ----------------------------------------------------------------------------
// Each sample transfer is written to the sample memory, unless the series
// length is zero. When a bucket's successor is complete the block stops
// taking samples, passes through the setup states SETUP_A, SETUP_B and
// SETUP_C and then walks the closed bucket through the single read port of
// the sample memory, reading, multiplying and comparing one sample at a time
// in WALK_RD, WALK_MUL and WALK_CMP. It then emits the chosen index from
// EMIT_SEL and, at the end of a series, the last index from EMIT_LAST. Every
// emit waits for as long as the result side stalls. After reset and after
// every configuration write the bucket step N-2 / T-2 is worked out by a
// serial divider, during which no sample is taken (the divider is skipped
// when every index is passed through). The sample memory needs no clearing pass.
`default_nettype none

`include "lttb_downsample_selector_macros.svh"

module lttb_downsample_selector #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  lttbds_pkg::t_cfg_reg           i_cfg_idx,
    input  logic [lttbds_pkg::CFG_W-1:0]   i_cfg_data,
    lttbds_sample_if.sink                  i_sample,
    lttbds_result_if.source                o_result
);
    import lttbds_pkg::*;

    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int NW  = AW + 1;
    localparam int QW  = NW + 1;
    localparam int SW  = SAMPLE_BITS;
    localparam int SXW = 2 * AW + 1;
    localparam int DXW = 2 * AW + 2;
    localparam int SYW = SW + AW + 1;
    localparam int DYW = SW + AW + 2;
    localparam int LOW = DYW / 2;
    localparam int HIW = DYW - LOW;
    localparam int PW  = DXW + SW + 1;
    localparam int VW  = DYW + AW + 3;

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_num, r_outp;
    logic [NW-1:0]        r_count;
    logic [AW-1:0]        r_ax;
    logic signed [SW-1:0] r_ay;
    logic signed [SXW-1:0] r_sx;
    logic signed [SYW-1:0] r_sy;
    logic [NW-1:0]        r_cnt;

    logic [QW-1:0] r_q0, r_q1, r_q2, r_qs, r_q2i;
    logic [NW-1:0] r_r2, r_rs, r_r2i;

    logic                  r_final;
    logic signed [DXW-1:0] r_dx;
    logic signed [DYW-1:0] r_dy;
    logic signed [VW-1:0]  r_t2;
    logic [AW-1:0]         r_j, r_e;
    logic signed [PW-1:0]  r_p1;
    logic signed [SW-1:0]  r_ycur;
    logic [VW-1:0]         r_best;
    logic                  r_have;
    logic [AW-1:0]         r_sel;
    logic signed [SW-1:0]  r_selval;

    logic              r_ov;
    logic [KEPT_W-1:0] r_oidx;
    logic              r_olast;

    logic [SW-1:0] mem [MAX_SAMPLES];
    logic [SW-1:0] r_rd;

    // ------------------------------------------------------ series geometry
    logic [NW-1:0] w_n, w_nm1, w_p, w_div_d, w_div_e;
    logic          w_pass;
    logic [AW-1:0] w_s, w_e, w_ns, w_ne;

    always_comb begin
        if (int'(r_num) > MAX_SAMPLES) begin
            w_n = NW'(MAX_SAMPLES);
        end else begin
            w_n = NW'(r_num);
        end
    end

    assign w_pass  = (int'(r_outp) >= int'(w_n)) || (int'(r_outp) < MIN_OUT_POINTS);
    assign w_nm1   = w_n - NW'(1);
    assign w_div_d = w_n - NW'(2);
    assign w_div_e = NW'(r_outp - CFG_W'(2));
    assign w_p     = (r_count >= w_n) ? '0 : r_count;

    function automatic logic [AW-1:0] f_bound(input logic [QW-1:0] q,
                                              input logic [AW-1:0] lim);
        logic [QW:0] b;
        b = {1'b0, q} + (QW+1)'(1);
        if (b >= (QW+1)'(lim)) return lim;
        return AW'(b);
    endfunction

    assign w_s  = f_bound(r_q0, w_nm1[AW-1:0]);
    assign w_e  = f_bound(r_q1, w_nm1[AW-1:0]);
    assign w_ns = w_e;
    assign w_ne = f_bound(r_q2, w_nm1[AW-1:0]);

    // boundary accumulator step: (q, r) + (Q, R) modulo the divisor
    logic [QW-1:0] w_st_q_in, w_st_q;
    logic [NW-1:0] w_st_r_in, w_st_r;
    logic [NW:0]   w_st_sum;

    assign w_st_q_in = (r_state == S_INIT) ? r_qs : r_q2;
    assign w_st_r_in = (r_state == S_INIT) ? r_rs : r_r2;
    assign w_st_sum  = {1'b0, w_st_r_in} + {1'b0, r_rs};

    always_comb begin
        if (w_st_sum >= {1'b0, w_div_e}) begin
            w_st_r = NW'(w_st_sum - {1'b0, w_div_e});
            w_st_q = w_st_q_in + r_qs + QW'(1);
        end else begin
            w_st_r = NW'(w_st_sum);
            w_st_q = w_st_q_in + r_qs;
        end
    end

    // ------------------------------------------------------------- divider
    logic          w_div_start, w_div_done;
    logic [NW-1:0] w_div_q, w_div_r;

    lttbds_div #(.W(NW)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_d),
        .i_divisor   (w_div_e),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    // ------------------------------------------------------ handshake side
    logic          w_in_ready, w_acc, w_out_free, w_out_load, w_out_last, w_rd_en;
    logic [NW-1:0] w_out_pos;
    logic          w_in_next, w_close, w_live;
    logic signed [SW-1:0] w_smp;

    assign w_smp      = SW'(i_sample.sample);
    assign w_out_free = !r_ov || o_result.ready;
    assign w_acc      = i_sample.valid && w_in_ready;
    assign w_live     = w_acc && (w_n != '0);
    assign w_in_next  = (w_p >= {1'b0, w_ns}) && (w_p < {1'b0, w_ne});
    assign w_close    = w_in_next && (w_p == ({1'b0, w_ne} - NW'(1)));

    // ------------------------------------------------------- walk datapath
    logic signed [AW:0]    w_axs;
    logic signed [AW+LOW+1:0] w_t2lo;
    logic signed [AW+HIW:0]   w_t2hi;
    logic signed [SW:0]    w_yd;
    logic signed [PW-1:0]  w_p1;
    logic signed [VW-1:0]  w_v;
    logic [VW-1:0]         w_mag;
    logic [AW+NW-1:0]      w_axcnt;
    logic signed [SW+NW:0] w_aycnt;
    logic                  w_walk_end;

    assign w_axs   = $signed({1'b0, r_ax}) - $signed({1'b0, r_j});
    assign w_t2lo  = w_axs * $signed({1'b0, r_dy[LOW-1:0]});
    assign w_t2hi  = w_axs * $signed(r_dy[DYW-1:LOW]);
    assign w_yd    = $signed({r_rd[SW-1], r_rd}) - $signed({r_ay[SW-1], r_ay});
    assign w_p1    = r_dx * w_yd;
    assign w_v     = VW'(r_p1) - r_t2;
    assign w_mag   = w_v[VW-1] ? VW'(-w_v) : VW'(w_v);
    assign w_axcnt = r_ax * r_cnt;
    assign w_aycnt = r_ay * $signed({1'b0, r_cnt});
    assign w_walk_end = (({1'b0, r_j} + (AW+1)'(1)) >= {1'b0, r_e});

    // ----------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = S_PREP;
        end else begin
            unique case (r_state)
                S_PREP:      n_state = w_pass ? S_INIT : S_DIV;
                S_DIV:       if (w_div_done) n_state = S_INIT;
                S_INIT:      n_state = S_IDLE;
                S_IDLE: begin
                    if (w_live && !w_pass && (w_p != '0) && ((w_p == w_nm1) || w_close)) begin
                        n_state = S_SETUP_A;
                    end
                end
                S_SETUP_A:   n_state = S_SETUP_B;
                S_SETUP_B:   n_state = S_SETUP_C;
                S_SETUP_C:   n_state = (r_j >= r_e) ? S_EMIT_SEL : S_WALK_RD;
                S_WALK_RD:   n_state = S_WALK_MUL;
                S_WALK_MUL:  n_state = S_WALK_CMP;
                S_WALK_CMP:  n_state = w_walk_end ? S_EMIT_SEL : S_WALK_RD;
                S_EMIT_SEL: begin
                    if (w_out_free) n_state = r_final ? S_EMIT_LAST : S_IDLE;
                end
                S_EMIT_LAST: if (w_out_free) n_state = S_IDLE;
                default:     n_state = S_PREP;
            endcase
        end
    end

    // -------------------------------------------------------------- outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_out_load  = 1'b0;
        w_out_pos   = '0;
        w_out_last  = 1'b0;
        w_rd_en     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_PREP:  w_div_start = !w_pass;
            S_IDLE: begin
                w_in_ready = w_out_free;
                if (w_live && (w_pass || (w_p == '0))) begin
                    w_out_load = 1'b1;
                    w_out_pos  = w_pass ? w_p : '0;
                    w_out_last = w_pass && (w_p == w_nm1);
                end
            end
            S_WALK_RD: w_rd_en = 1'b1;
            S_EMIT_SEL: begin
                w_out_load = w_out_free;
                w_out_pos  = {1'b0, r_sel};
            end
            S_EMIT_LAST: begin
                w_out_load = w_out_free;
                w_out_pos  = w_nm1;
                w_out_last = 1'b1;
            end
            default: ;
        endcase
    end

    assign i_sample.ready      = w_in_ready;
    assign o_result.valid      = r_ov;
    assign o_result.kept_index = r_oidx;
    assign o_result.last       = r_olast;

    // ------------------------------------------------------ control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PREP;
            r_num   <= '0;
            r_outp  <= CFG_W'(1000);
            r_count <= '0;
            r_ax    <= '0;
            r_ay    <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_result.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NUM_SAMPLES: r_num  <= i_cfg_data;
                    REG_OUT_POINTS:  r_outp <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_INIT: begin
                    r_count <= '0;
                    r_ax    <= '0;
                    r_ay    <= '0;
                    r_sx    <= '0;
                    r_sy    <= '0;
                    r_cnt   <= '0;
                end
                S_IDLE: begin
                    if (w_live) begin
                        if (w_pass) begin
                            r_count <= (w_p == w_nm1) ? '0 : w_p + NW'(1);
                        end else if (w_p == '0) begin
                            r_ax    <= '0;
                            r_ay    <= w_smp;
                            r_count <= NW'(1);
                        end else if (w_p == w_nm1) begin
                            // final bucket: C is the last point itself
                            r_sx  <= SXW'(w_nm1);
                            r_sy  <= SYW'(w_smp);
                            r_cnt <= NW'(1);
                        end else begin
                            if (w_in_next) begin
                                r_sx  <= r_sx + SXW'(w_p);
                                r_sy  <= r_sy + SYW'(w_smp);
                                r_cnt <= r_cnt + NW'(1);
                            end
                            r_count <= w_p + NW'(1);
                        end
                    end
                end
                S_EMIT_SEL: begin
                    if (w_out_free && !r_final) begin
                        r_ax  <= r_sel;
                        r_ay  <= r_selval;
                        r_sx  <= '0;
                        r_sy  <= '0;
                        r_cnt <= '0;
                    end
                end
                S_EMIT_LAST: begin
                    if (w_out_free) begin
                        r_count <= '0;
                        r_ax    <= '0;
                        r_ay    <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_cnt   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------ working regs
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_oidx  <= KEPT_W'(32'(w_out_pos));
            r_olast <= w_out_last;
        end
        case (r_state)
            S_DIV: begin
                if (w_div_done) begin
                    r_qs <= QW'(w_div_q);
                    r_rs <= w_div_r;
                end
            end
            S_INIT: begin
                r_q0  <= '0;
                r_q1  <= r_qs;
                r_q2  <= w_st_q;
                r_r2  <= w_st_r;
                r_q2i <= w_st_q;
                r_r2i <= w_st_r;
            end
            S_IDLE: begin
                if (w_live) r_final <= (w_p == w_nm1);
            end
            S_SETUP_A: begin
                r_dx   <= $signed({1'b0, w_axcnt}) - DXW'(r_sx);
                r_dy   <= DYW'(r_sy) - DYW'(w_aycnt);
                r_j    <= w_s;
                r_e    <= w_e;
                r_sel  <= w_s;
                r_selval <= r_ay;
                r_have <= 1'b0;
            end
            S_SETUP_B: r_t2 <= VW'(w_t2lo);
            S_SETUP_C: r_t2 <= r_t2 + (VW'(w_t2hi) <<< LOW);
            S_WALK_MUL: begin
                r_p1   <= w_p1;
                r_ycur <= r_rd;
            end
            S_WALK_CMP: begin
                // strict compare keeps the first maximum
                if (!r_have || (w_mag > r_best)) begin
                    r_best   <= w_mag;
                    r_sel    <= r_j;
                    r_selval <= r_ycur;
                    r_have   <= 1'b1;
                end
                r_t2 <= r_t2 - VW'(r_dy);
                r_j  <= r_j + AW'(1);
            end
            S_EMIT_SEL: begin
                if (w_out_free && !r_final) begin
                    r_q0 <= r_q1;
                    r_q1 <= r_q2;
                    r_q2 <= w_st_q;
                    r_r2 <= w_st_r;
                end
            end
            S_EMIT_LAST: begin
                if (w_out_free) begin
                    r_q0 <= '0;
                    r_q1 <= r_qs;
                    r_q2 <= r_q2i;
                    r_r2 <= r_r2i;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------- sample memory
    always_ff @(posedge i_clk) begin
        if (w_live) begin
            mem[w_p[AW-1:0]] <= w_smp;
        end
        if (w_rd_en) begin
            r_rd <= mem[r_j];
        end
    end

    // ---------------------------------------------------------- assertions
    `LTTBDS_ASSERT_SAME(a_walk_in_range, r_state == S_WALK_RD, r_j < r_e, "walk past bucket end")
    `LTTBDS_ASSERT_SAME(a_sums_nonempty, r_state == S_SETUP_A, r_cnt != '0, "empty next bucket")
    `LTTBDS_ASSERT_NEXT(a_series_restart, (r_state == S_EMIT_LAST) && w_out_free,
                        r_count == '0, "series not restarted")
endmodule

`default_nettype wire

// ----- tb/sv/lttbds_checker.sv -----
// ----------------------------------------------------------------------------
// lttbds_checker
// Watches the configuration port and both channels of the LTTB selector. It
// keeps its own copy of the series state, works out the kept indices of each
// sample transfer and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module lttbds_checker
    import lttbds_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_reg         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    lttbds_sample_if         smp,
    lttbds_result_if         res,
    output int               o_pending,
    output int               o_errors,
    output int               o_results
);

    localparam int DEPTH = 4096;

    typedef struct {
        logic [KEPT_W-1:0] idx;
        logic              last;
    } t_kept;

    t_kept       kept_q[$];

    logic [CFG_W-1:0] series_len;
    logic [CFG_W-1:0] keep_count;
    longint      sample_mem[DEPTH];
    int unsigned pos_cnt;
    int unsigned bucket;
    int unsigned anchor_pos;
    longint      anchor_val;
    longint      nxt_sum_pos;
    longint      nxt_sum_val;
    longint      nxt_cnt;

    function automatic void restart();
        pos_cnt     = 0;
        bucket      = 0;
        anchor_pos  = 0;
        anchor_val  = 0;
        nxt_sum_pos = 0;
        nxt_sum_val = 0;
        nxt_cnt     = 0;
    endfunction

    // append one expected kept index
    function automatic void add_kept(logic [KEPT_W-1:0] idx, logic last);
        t_kept k;
        k.idx  = idx;
        k.last = last;
        kept_q.insert(kept_q.size(), k);
    endfunction

    // first position of bucket k, clamped to the last sample
    function automatic int unsigned bkt_first(int unsigned k, int unsigned n,
                                              int unsigned t);
        longint b;
        b = 1 + (longint'(k) * longint'(n - 2)) / longint'(t - 2);
        return (b > longint'(n - 1)) ? n - 1 : int'(b);
    endfunction

    // largest count-scaled triangle area, first maximum wins
    function automatic int unsigned pick_point(int unsigned k, int unsigned n,
                                               int unsigned t, longint sx,
                                               longint sy, longint c);
        int unsigned s, e, sel;
        longint ax, ay, dx, dy, v;
        longint unsigned mag, best;
        bit have;
        s    = bkt_first(k, n, t);
        e    = bkt_first(k + 1, n, t);
        ax   = longint'(anchor_pos);
        ay   = anchor_val;
        dx   = ax * c - sx;
        dy   = sy - ay * c;
        best = 0;
        sel  = s;
        have = 0;
        for (int unsigned j = s; j < e && j < DEPTH; j++) begin
            v   = dx * (sample_mem[j] - ay) - (ax - longint'(j)) * dy;
            mag = (v < 0) ? longint'(-v) : v;
            if (!have || mag > best) begin
                best = mag;
                sel  = j;
                have = 1;
            end
        end
        return sel;
    endfunction

    function automatic void predict(logic signed [31:0] smp_val);
        int unsigned n, t, p, k, ns, ne, sel;
        longint v;
        n = (series_len > DEPTH) ? DEPTH : series_len;
        t = keep_count;
        if (n == 0) return;
        p = (pos_cnt >= n) ? 0 : pos_cnt;
        v = longint'(smp_val);
        sample_mem[p] = v;
        if (t >= n || t < MIN_OUT_POINTS) begin
            add_kept(p[KEPT_W-1:0], (p == n - 1));
            if (p == n - 1) restart();
            else pos_cnt = p + 1;
            return;
        end
        if (p == 0) begin
            anchor_pos = 0;
            anchor_val = v;
            add_kept('0, 1'b0);
            pos_cnt = 1;
            return;
        end
        if (p == n - 1) begin
            // final bucket: the last point stands in for the empty next bucket
            sel = pick_point(bucket, n, t, longint'(n - 1), v, 1);
            add_kept(sel[KEPT_W-1:0], 1'b0);
            add_kept(p[KEPT_W-1:0], 1'b1);
            restart();
            return;
        end
        k  = bucket;
        ns = bkt_first(k + 1, n, t);
        ne = bkt_first(k + 2, n, t);
        if (p >= ns && p < ne) begin
            nxt_sum_pos += longint'(p);
            nxt_sum_val += v;
            nxt_cnt     += 1;
            if (p == ne - 1) begin
                sel = pick_point(k, n, t, nxt_sum_pos, nxt_sum_val, nxt_cnt);
                add_kept(sel[KEPT_W-1:0], 1'b0);
                anchor_pos  = sel;
                anchor_val  = sample_mem[sel];
                bucket      = k + 1;
                nxt_sum_pos = 0;
                nxt_sum_val = 0;
                nxt_cnt     = 0;
            end
        end
        pos_cnt = p + 1;
    endfunction

    always @(posedge i_clk) begin
        t_kept exp_k;
        if (!i_rst_n) begin
            series_len = '0;
            keep_count = CFG_W'(1000);
            restart();
            kept_q.delete();
            o_errors  = 0;
            o_results = 0;
        end else begin
            if (res.valid && res.ready) begin
                o_results++;
                if (kept_q.size() == 0) begin
                    $error("kept_index: unexpected transfer, actual %0d", res.kept_index);
                    o_errors++;
                end else begin
                    exp_k = kept_q.pop_front();
                    if (res.kept_index !== exp_k.idx) begin
                        $error("kept_index: expected %0d, actual %0d",
                               exp_k.idx, res.kept_index);
                        o_errors++;
                    end
                    if (res.last !== exp_k.last) begin
                        $error("last: expected %0d, actual %0d", exp_k.last, res.last);
                        o_errors++;
                    end
                end
            end
            if (smp.valid && smp.ready) predict(smp.sample);
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_NUM_SAMPLES) series_len = i_cfg_data;
                else keep_count = i_cfg_data;
                restart();
            end
        end
        o_pending = kept_q.size();
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LTTB selector: directed series over the corner settings,
// then random series of random length and bucket count, with aborted series,
// random stalls on both channels and a partial series at the clamped length.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import lttbds_pkg::*;

    localparam int LIMIT = 600000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_reg         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    int  pending, errors, results;
    int  cycles;
    int  n_items;
    int  n_cfg;
    bit  steady;

    lttbds_sample_if #(.W(32)) smp_if ();
    lttbds_result_if           res_if ();

    lttb_downsample_selector DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_sample  (smp_if),
        .o_result  (res_if)
    );

    lttbds_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .smp       (smp_if),
        .res       (res_if),
        .o_pending (pending),
        .o_errors  (errors),
        .o_results (results)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit stall_now();
        return !steady && ($urandom_range(99) < 13);
    endfunction

    always @(negedge i_clk) res_if.ready <= !stall_now();

    task automatic push_sample(logic [31:0] v);
        @(negedge i_clk);
        while (stall_now()) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= v;
        do @(posedge i_clk); while (!smp_if.ready);
        n_items++;
    endtask

    // lower valid and wait for every outstanding kept index
    task automatic drain();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic reg_write(t_cfg_reg idx, int unsigned val);
        drain();
        repeat (40) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        n_cfg++;
    endtask

    task automatic setup(int unsigned n, int unsigned t);
        reg_write(REG_NUM_SAMPLES, n);
        reg_write(REG_OUT_POINTS, t);
    endtask

    task automatic rand_series(int unsigned len);
        for (int unsigned i = 0; i < len; i++) push_sample($urandom());
    endtask

    initial begin
        int unsigned n, t, reps;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_NUM_SAMPLES;
        i_cfg_data    = '0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        n_items       = 0;
        n_cfg         = 0;
        steady        = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty series: samples are dropped
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        setup(0, 1000);
        push_sample(32'h1234_5678);
        // pass-through, T above N
        setup(5, 8191);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h0000_0001);
        // pass-through, T below three
        setup(4, 2);
        rand_series(4);
        reg_write(REG_OUT_POINTS, 0);
        rand_series(3);
        // smallest real selection, one bucket closed by the last point
        setup(4, 3);
        push_sample(32'h0000_0000);
        push_sample(32'h8000_0000);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h0001_0000);
        // several buckets, with a full drain in the middle of the series
        setup(10, 5);
        rand_series(5);
        drain();
        rand_series(5);

        while (n_items < 480) begin
            steady = (n_items > 300 && n_items < 420);
            n = ($urandom_range(9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
            t = $urandom_range(0, n + 3);
            if ($urandom_range(3) == 0) t = $urandom_range(3, 6);
            setup(n, t);
            reps = $urandom_range(1, 3);
            for (int unsigned r = 0; r < reps; r++) rand_series(n);
            // aborted series, ended by the next write
            if ($urandom_range(6) == 0) rand_series($urandom_range(0, n - 1));
        end
        steady = 0;

        // N beyond the store depth: clamped
        setup(8191, 8191);
        rand_series(30);
        setup(8191, 1000);
        rand_series(300);
        reg_write(REG_OUT_POINTS, 3);

        drain();
        repeat (60) @(negedge i_clk);
        $display("Sent %0d samples over %0d register writes, checked %0d kept indices.",
                 n_items, n_cfg, results);
        $display("Covered pass-through, empty, clamped and aborted series, T from 0 to 8191.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
